@@ rtl/iss_pkg.sv @@
package iss_pkg;

  localparam int TIMEOUT_W = 20;
  localparam int WARN_W    = 20;
  localparam int PULSE_W   = 10;
  localparam int CFG_DW    = 20;
  localparam int CFG_AW    = 2;
  localparam int REMAIN_W  = 20;

  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = TIMEOUT_W'(60000);
  localparam logic [WARN_W-1:0]    WARN_WINDOW_RST  = WARN_W'(500);
  localparam logic [PULSE_W-1:0]   RELAY_PULSE_RST  = PULSE_W'(800);

  localparam logic [CFG_AW-1:0] CFG_IDLE_TIMEOUT = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_WARN_WINDOW  = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_RELAY_PULSE  = CFG_AW'(2);

  localparam logic [1:0] HEALTH_OK      = 2'd0;
  localparam logic [1:0] HEALTH_CAN_ERR = 2'd1;
  localparam logic [1:0] HEALTH_CAN_TMO = 2'd2;
  localparam logic [1:0] HEALTH_OTHER   = 2'd3;

  localparam logic [1:0] COND_WORKING = 2'd0;
  localparam logic [1:0] COND_IDLE    = 2'd1;
  localparam logic [1:0] COND_UNKNOWN = 2'd2;

  typedef enum logic [2:0] {
    MODE_MON   = 3'd0,
    MODE_IDLE  = 3'd1,
    MODE_TIMER = 3'd2,
    MODE_SDREQ = 3'd3,
    MODE_SDACT = 3'd4,
    MODE_FAULT = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CTX_MON   = 2'd0,
    CTX_FAULT = 2'd1,
    CTX_SDACT = 2'd2
  } ctx_e;

  typedef struct packed {
    logic relay;
    logic green;
    logic red;
    logic led_a;
    logic led_b;
  } lamps_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] idle_timeout;
    logic [WARN_W-1:0]    warn_window;
    logic [PULSE_W-1:0]   relay_pulse;
  } cfg_t;

endpackage

@@ rtl/iss_cfg_regs.sv @@
module iss_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [iss_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [iss_pkg::CFG_DW-1:0]  cfg_wdata_i,
  output iss_pkg::cfg_t               cfg_o
);

  iss_pkg::cfg_t cfg_q;
  iss_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        iss_pkg::CFG_IDLE_TIMEOUT: begin
          cfg_d.idle_timeout = cfg_wdata_i[iss_pkg::TIMEOUT_W-1:0];
        end
        iss_pkg::CFG_WARN_WINDOW: begin
          cfg_d.warn_window = cfg_wdata_i[iss_pkg::WARN_W-1:0];
        end
        iss_pkg::CFG_RELAY_PULSE: begin
          cfg_d.relay_pulse = cfg_wdata_i[iss_pkg::PULSE_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout <= iss_pkg::IDLE_TIMEOUT_RST;
      cfg_q.warn_window  <= iss_pkg::WARN_WINDOW_RST;
      cfg_q.relay_pulse  <= iss_pkg::RELAY_PULSE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/iss_step.sv @@
module iss_step #(
  parameter int TIMER_BITS = 20,
  parameter int PULSE_BITS = 10
) (
  input  iss_pkg::mode_e                   mode_i,
  input  iss_pkg::ctx_e                    ctx_i,
  input  logic [TIMER_BITS-1:0]            elapsed_i,
  input  logic                             running_i,
  input  logic [PULSE_BITS-1:0]            pulse_i,
  input  iss_pkg::lamps_t                  lamps_i,
  input  iss_pkg::cfg_t                    cfg_i,
  input  logic [1:0]                       health_i,
  input  logic [1:0]                       cond_i,
  output iss_pkg::mode_e                   mode_o,
  output iss_pkg::ctx_e                    ctx_o,
  output logic [TIMER_BITS-1:0]            elapsed_o,
  output logic                             running_o,
  output logic [PULSE_BITS-1:0]            pulse_o,
  output iss_pkg::lamps_t                  lamps_o,
  output logic [iss_pkg::REMAIN_W-1:0]     remaining_o
);

  localparam int CW  = (TIMER_BITS > iss_pkg::TIMEOUT_W) ? TIMER_BITS : iss_pkg::TIMEOUT_W;
  localparam int PCW = (PULSE_BITS > iss_pkg::PULSE_W) ? PULSE_BITS : iss_pkg::PULSE_W;

  logic [CW-1:0]         to_w;
  logic [CW-1:0]         el_w;
  logic [CW-1:0]         el1_w;
  logic [CW-1:0]         nel_w;
  logic [CW-1:0]         tmax_w;
  logic [CW-1:0]         rem_cur;
  logic [CW-1:0]         rem_nxt;
  logic [TIMER_BITS-1:0] el1;
  logic [PULSE_BITS-1:0] pc1;
  logic                  warn;
  logic                  expired;
  logic                  released;

  assign to_w   = CW'(cfg_i.idle_timeout);
  assign el_w   = CW'(elapsed_i);
  assign tmax_w = CW'({TIMER_BITS{1'b1}});

  always_comb begin
    el1 = elapsed_i;
    if (running_i && (el_w < to_w) && (el_w < tmax_w)) begin
      el1 = elapsed_i + TIMER_BITS'(1);
    end
  end

  assign el1_w   = CW'(el1);
  assign rem_cur = (running_i && (el1_w < to_w)) ? (to_w - el1_w) : '0;
  assign warn    = (rem_cur <= CW'(cfg_i.warn_window));
  assign expired = running_i && (el1_w >= to_w);

  assign pc1      = (pulse_i != {PULSE_BITS{1'b1}}) ? (pulse_i + PULSE_BITS'(1)) : pulse_i;
  assign released = (PCW'(pc1) >= PCW'(cfg_i.relay_pulse));

  always_comb begin
    mode_o    = mode_i;
    ctx_o     = ctx_i;
    elapsed_o = el1;
    running_o = running_i;
    pulse_o   = pulse_i;
    lamps_o   = lamps_i;
    if ((health_i == iss_pkg::HEALTH_CAN_ERR) || (health_i == iss_pkg::HEALTH_CAN_TMO)) begin
      running_o = 1'b0;
      elapsed_o = '0;
      mode_o    = iss_pkg::MODE_FAULT;
      ctx_o     = iss_pkg::CTX_FAULT;
    end else begin
      case (mode_i)
        iss_pkg::MODE_MON: begin
          if (cond_i == iss_pkg::COND_WORKING) begin
            lamps_o.led_a = 1'b1;
            lamps_o.led_b = 1'b1;
            lamps_o.relay = 1'b0;
            lamps_o.red   = 1'b0;
            lamps_o.green = 1'b0;
            running_o     = 1'b0;
            elapsed_o     = '0;
            mode_o        = iss_pkg::MODE_MON;
            ctx_o         = iss_pkg::CTX_MON;
          end else if (cond_i == iss_pkg::COND_IDLE) begin
            mode_o = iss_pkg::MODE_IDLE;
            ctx_o  = iss_pkg::CTX_MON;
          end
        end
        iss_pkg::MODE_IDLE: begin
          running_o     = 1'b1;
          elapsed_o     = '0;
          mode_o        = iss_pkg::MODE_TIMER;
          ctx_o         = iss_pkg::CTX_MON;
          lamps_o.relay = 1'b0;
          lamps_o.green = 1'b1;
          lamps_o.led_a = 1'b0;
          lamps_o.led_b = 1'b1;
        end
        iss_pkg::MODE_TIMER: begin
          if (warn) begin
            lamps_o.red   = 1'b1;
            lamps_o.led_a = 1'b1;
            lamps_o.led_b = 1'b0;
          end else begin
            lamps_o.red   = 1'b0;
            lamps_o.led_b = 1'b1;
          end
          if (cond_i != iss_pkg::COND_IDLE) begin
            lamps_o.relay = 1'b0;
            lamps_o.red   = 1'b0;
            lamps_o.green = 1'b0;
            running_o     = 1'b0;
            elapsed_o     = '0;
            mode_o        = iss_pkg::MODE_MON;
            ctx_o         = iss_pkg::CTX_MON;
          end else if (expired) begin
            mode_o = iss_pkg::MODE_SDREQ;
            ctx_o  = iss_pkg::CTX_MON;
          end
        end
        iss_pkg::MODE_SDREQ: begin
          if ((cond_i == iss_pkg::COND_IDLE) && (health_i == iss_pkg::HEALTH_OK)) begin
            lamps_o.relay = 1'b1;
            pulse_o       = '0;
            lamps_o.led_a = 1'b1;
            lamps_o.led_b = 1'b0;
            mode_o        = iss_pkg::MODE_SDACT;
            ctx_o         = iss_pkg::CTX_SDACT;
          end else begin
            mode_o = iss_pkg::MODE_MON;
            ctx_o  = iss_pkg::CTX_MON;
          end
        end
        iss_pkg::MODE_SDACT: begin
          pulse_o = pc1;
          if (released) begin
            lamps_o.relay = 1'b0;
            mode_o        = iss_pkg::MODE_MON;
            ctx_o         = iss_pkg::CTX_SDACT;
          end
        end
        default: begin
          mode_o = iss_pkg::MODE_FAULT;
        end
      endcase
    end
  end

  assign nel_w       = CW'(elapsed_o);
  assign rem_nxt     = (running_o && (nel_w < to_w)) ? (to_w - nel_w) : '0;
  assign remaining_o = rem_nxt[iss_pkg::REMAIN_W-1:0];

endmodule

@@ rtl/idle_stop_supervisor_core.sv @@
// Idle-stop supervisor, one transaction per millisecond tick.
// Input channel: in_valid_i / in_stall_o with health_i and condition_i.
// Output channel: out_valid_o / out_stall_i with the mode, the lamp,
// relay and LED latches, the health context and the idle countdown.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 idle timeout, 1 warning window, 2 relay pulse); other indexes are
// ignored. Write only while no transaction is in flight.
// A taken input transaction is held in the input register, and the mode
// update runs from the input register into the result register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the mode update is a single pass of logic on the stored state.
// Reset puts the block in monitor mode with the timer stopped, all
// latches off and the configuration at 60000 / 500 / 800.
// When the receiver stalls, the result holds; the input register keeps
// accepting until it is full, then in_stall_o rises.
module idle_stop_supervisor_core #(
  parameter int TIMER_BITS = 20,
  parameter int PULSE_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       health_i,
  input  logic [1:0]                       condition_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       mode_o,
  output logic                             relay_on_o,
  output logic                             green_lamp_o,
  output logic                             red_lamp_o,
  output logic                             led_a_o,
  output logic                             led_b_o,
  output logic [1:0]                       health_context_o,
  output logic [iss_pkg::REMAIN_W-1:0]     remaining_o,
  input  logic                             cfg_we_i,
  input  logic [iss_pkg::CFG_AW-1:0]       cfg_idx_i,
  input  logic [iss_pkg::CFG_DW-1:0]       cfg_wdata_i
);

  iss_pkg::cfg_t cfg;

  logic       s1_valid_q;
  logic [1:0] s1_health_q;
  logic [1:0] s1_cond_q;
  logic       free2;
  logic       adv2;

  iss_pkg::mode_e        mode_q, mode_d;
  iss_pkg::ctx_e         ctx_q, ctx_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic                  running_q, running_d;
  logic [PULSE_BITS-1:0] pulse_q, pulse_d;
  iss_pkg::lamps_t       lamps_q, lamps_d;
  logic [iss_pkg::REMAIN_W-1:0] remaining_d;

  logic                         out_valid_q;
  iss_pkg::mode_e               out_mode_q;
  iss_pkg::ctx_e                out_ctx_q;
  iss_pkg::lamps_t              out_lamps_q;
  logic [iss_pkg::REMAIN_W-1:0] out_remaining_q;

  iss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign free2      = !out_valid_q || !out_stall_i;
  assign adv2       = s1_valid_q && free2;
  assign in_stall_o = s1_valid_q && !free2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_health_q <= health_i;
      s1_cond_q   <= condition_i;
    end
  end

  iss_step #(
    .TIMER_BITS (TIMER_BITS),
    .PULSE_BITS (PULSE_BITS)
  ) u_step (
    .mode_i      (mode_q),
    .ctx_i       (ctx_q),
    .elapsed_i   (elapsed_q),
    .running_i   (running_q),
    .pulse_i     (pulse_q),
    .lamps_i     (lamps_q),
    .cfg_i       (cfg),
    .health_i    (s1_health_q),
    .cond_i      (s1_cond_q),
    .mode_o      (mode_d),
    .ctx_o       (ctx_d),
    .elapsed_o   (elapsed_d),
    .running_o   (running_d),
    .pulse_o     (pulse_d),
    .lamps_o     (lamps_d),
    .remaining_o (remaining_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= iss_pkg::MODE_MON;
      ctx_q     <= iss_pkg::CTX_MON;
      elapsed_q <= '0;
      running_q <= 1'b0;
      pulse_q   <= '0;
      lamps_q   <= '0;
    end else if (adv2) begin
      mode_q    <= mode_d;
      ctx_q     <= ctx_d;
      elapsed_q <= elapsed_d;
      running_q <= running_d;
      pulse_q   <= pulse_d;
      lamps_q   <= lamps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (free2) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      out_mode_q      <= mode_d;
      out_ctx_q       <= ctx_d;
      out_lamps_q     <= lamps_d;
      out_remaining_q <= remaining_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_o           = out_mode_q;
  assign health_context_o = out_ctx_q;
  assign relay_on_o       = out_lamps_q.relay;
  assign green_lamp_o     = out_lamps_q.green;
  assign red_lamp_o       = out_lamps_q.red;
  assign led_a_o          = out_lamps_q.led_a;
  assign led_b_o          = out_lamps_q.led_b;
  assign remaining_o      = out_remaining_q;

endmodule

@@ rtl/iss_checker.sv @@
module iss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [2:0]                   mode_o,
  input logic                         relay_on_o,
  input logic [1:0]                   health_context_o,
  input logic [iss_pkg::REMAIN_W-1:0] remaining_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o) && $stable(remaining_o))
    else $error("stalled result changed");

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == iss_pkg::MODE_FAULT)
      |=> !out_valid_o || (mode_o == iss_pkg::MODE_FAULT))
    else $error("fault mode left without reset");

  a_fault_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == iss_pkg::MODE_FAULT) |-> health_context_o == iss_pkg::CTX_FAULT)
    else $error("fault mode without fault context");

  a_sdact_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == iss_pkg::MODE_SDACT)
      |-> relay_on_o && (health_context_o == iss_pkg::CTX_SDACT))
    else $error("shutdown active without relay drive");

  a_relay_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relay_on_o
      |-> (mode_o == iss_pkg::MODE_SDACT) || (mode_o == iss_pkg::MODE_FAULT))
    else $error("relay energized outside shutdown");

endmodule

bind idle_stop_supervisor_core iss_checker u_iss_checker (.*);

@@ test/idle_stop_supervisor_core_tb.sv @@
`timescale 1ns / 1ps

module idle_stop_supervisor_core_tb;

  localparam logic [1:0] COND_UNDEFINED = 2'd3;
  localparam logic [iss_pkg::CFG_AW-1:0] CFG_UNUSED = iss_pkg::CFG_AW'(3);
  localparam int PHASES = 8;

  typedef enum bit {STEP_TICK, STEP_WRITE} step_kind_e;

  typedef struct {
    step_kind_e                    kind;
    logic [1:0]                    health;
    logic [1:0]                    cond;
    logic [iss_pkg::CFG_AW-1:0]    idx;
    logic [iss_pkg::CFG_DW-1:0]    data;
    bit                            typed;
    iss_pkg::mode_e                mode;
    iss_pkg::ctx_e                 ctx;
    logic [iss_pkg::REMAIN_W-1:0]  remaining;
  } step_t;

  typedef struct packed {
    iss_pkg::mode_e               mode;
    iss_pkg::lamps_t              lamps;
    iss_pkg::ctx_e                ctx;
    logic [iss_pkg::REMAIN_W-1:0] remaining;
  } tick_out_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   health_i = iss_pkg::HEALTH_OK;
  logic [1:0]                   condition_i = iss_pkg::COND_WORKING;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [2:0]                   mode_o;
  logic                         relay_on_o;
  logic                         green_lamp_o;
  logic                         red_lamp_o;
  logic                         led_a_o;
  logic                         led_b_o;
  logic [1:0]                   health_context_o;
  logic [iss_pkg::REMAIN_W-1:0] remaining_o;
  logic                         cfg_we_i = 1'b0;
  logic [iss_pkg::CFG_AW-1:0]   cfg_idx_i = iss_pkg::CFG_IDLE_TIMEOUT;
  logic [iss_pkg::CFG_DW-1:0]   cfg_wdata_i = '0;

  idle_stop_supervisor_core dut (.*);

  // predictor state
  logic [iss_pkg::TIMEOUT_W-1:0] timeout_reg = iss_pkg::IDLE_TIMEOUT_RST;
  logic [iss_pkg::WARN_W-1:0]    warn_reg    = iss_pkg::WARN_WINDOW_RST;
  logic [iss_pkg::PULSE_W-1:0]   pulse_reg   = iss_pkg::RELAY_PULSE_RST;
  iss_pkg::mode_e                sup_mode    = iss_pkg::MODE_MON;
  iss_pkg::ctx_e                 sup_ctx     = iss_pkg::CTX_MON;
  logic [iss_pkg::TIMEOUT_W-1:0] idle_count  = '0;
  bit                            idle_on     = 1'b0;
  logic [iss_pkg::PULSE_W-1:0]   pulse_count = '0;
  iss_pkg::lamps_t               latch       = '0;

  tick_out_t due_ticks[$];
  step_t     script[$];
  int        tail_start;
  int        mismatches = 0;
  int        send_odds = 0;
  int        stall_odds = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [iss_pkg::REMAIN_W-1:0] countdown();
    if (!idle_on || idle_count >= timeout_reg) return '0;
    return timeout_reg - idle_count;
  endfunction

  function automatic void clear_to_monitor();
    idle_on = 1'b0;
    idle_count = '0;
    latch.relay = 1'b0;
    latch.red = 1'b0;
    latch.green = 1'b0;
    sup_mode = iss_pkg::MODE_MON;
    sup_ctx = iss_pkg::CTX_MON;
  endfunction

  function automatic tick_out_t advance_tick(logic [1:0] health, logic [1:0] cond);
    tick_out_t res;
    if (idle_on && idle_count < timeout_reg && idle_count != '1) idle_count++;
    if (health == iss_pkg::HEALTH_CAN_ERR || health == iss_pkg::HEALTH_CAN_TMO) begin
      idle_on = 1'b0;
      idle_count = '0;
      sup_mode = iss_pkg::MODE_FAULT;
      sup_ctx = iss_pkg::CTX_FAULT;
    end else begin
      case (sup_mode)
        iss_pkg::MODE_MON: begin
          if (cond == iss_pkg::COND_WORKING) begin
            latch.led_a = 1'b1;
            latch.led_b = 1'b1;
            clear_to_monitor();
          end else if (cond == iss_pkg::COND_IDLE) begin
            sup_mode = iss_pkg::MODE_IDLE;
            sup_ctx = iss_pkg::CTX_MON;
          end
        end
        iss_pkg::MODE_IDLE: begin
          idle_on = 1'b1;
          idle_count = '0;
          sup_mode = iss_pkg::MODE_TIMER;
          sup_ctx = iss_pkg::CTX_MON;
          latch.relay = 1'b0;
          latch.green = 1'b1;
          latch.led_a = 1'b0;
          latch.led_b = 1'b1;
        end
        iss_pkg::MODE_TIMER: begin
          if (countdown() <= warn_reg) begin
            latch.red = 1'b1;
            latch.led_a = 1'b1;
            latch.led_b = 1'b0;
          end else begin
            latch.red = 1'b0;
            latch.led_b = 1'b1;
          end
          if (cond != iss_pkg::COND_IDLE) begin
            clear_to_monitor();
          end else if (idle_on && idle_count >= timeout_reg) begin
            sup_mode = iss_pkg::MODE_SDREQ;
            sup_ctx = iss_pkg::CTX_MON;
          end
        end
        iss_pkg::MODE_SDREQ: begin
          if (cond == iss_pkg::COND_IDLE && health == iss_pkg::HEALTH_OK) begin
            latch.relay = 1'b1;
            pulse_count = '0;
            latch.led_a = 1'b1;
            latch.led_b = 1'b0;
            sup_mode = iss_pkg::MODE_SDACT;
            sup_ctx = iss_pkg::CTX_SDACT;
          end else begin
            sup_mode = iss_pkg::MODE_MON;
            sup_ctx = iss_pkg::CTX_MON;
          end
        end
        iss_pkg::MODE_SDACT: begin
          if (pulse_count != '1) pulse_count++;
          if (pulse_count >= pulse_reg) begin
            latch.relay = 1'b0;
            sup_mode = iss_pkg::MODE_MON;
            sup_ctx = iss_pkg::CTX_SDACT;
          end
        end
        default: sup_mode = iss_pkg::MODE_FAULT;
      endcase
    end
    res.mode = sup_mode;
    res.lamps = latch;
    res.ctx = sup_ctx;
    res.remaining = countdown();
    return res;
  endfunction

  function automatic step_t tick_row(logic [1:0] health, logic [1:0] cond);
    step_t r;
    r.kind = STEP_TICK;
    r.health = health;
    r.cond = cond;
    r.idx = '0;
    r.data = '0;
    r.typed = 1'b0;
    r.mode = iss_pkg::MODE_MON;
    r.ctx = iss_pkg::CTX_MON;
    r.remaining = '0;
    return r;
  endfunction

  function automatic step_t tick_typed(logic [1:0] health, logic [1:0] cond,
                                       iss_pkg::mode_e mode, iss_pkg::ctx_e ctx,
                                       logic [iss_pkg::REMAIN_W-1:0] remaining);
    step_t r;
    r = tick_row(health, cond);
    r.typed = 1'b1;
    r.mode = mode;
    r.ctx = ctx;
    r.remaining = remaining;
    return r;
  endfunction

  function automatic step_t write_row(logic [iss_pkg::CFG_AW-1:0] idx,
                                      logic [iss_pkg::CFG_DW-1:0] data);
    step_t r;
    r = tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_WORKING);
    r.kind = STEP_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_tick(input step_t row);
    tick_out_t want;
    @(negedge clk_i);
    if (send_odds != 0 && $urandom_range(0, send_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    health_i <= row.health;
    condition_i <= row.cond;
    do @(posedge clk_i); while (in_stall_o);
    want = advance_tick(row.health, row.cond);
    if (row.typed) begin
      want.mode = row.mode;
      want.ctx = row.ctx;
      want.remaining = row.remaining;
    end
    due_ticks.push_back(want);
  endtask

  // drop valid and hold until every result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_ticks.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [iss_pkg::CFG_AW-1:0] idx,
                           input logic [iss_pkg::CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      iss_pkg::CFG_IDLE_TIMEOUT: timeout_reg = data[iss_pkg::TIMEOUT_W-1:0];
      iss_pkg::CFG_WARN_WINDOW:  warn_reg = data[iss_pkg::WARN_W-1:0];
      iss_pkg::CFG_RELAY_PULSE:  pulse_reg = data[iss_pkg::PULSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic walk_script(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      if (script[i].kind == STEP_WRITE) begin
        drain();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_tick(script[i]);
      end
    end
  endtask

  task automatic run_phase(input int budget);
    int sent;
    int span;
    int n;
    logic [1:0] health;
    logic [1:0] cond;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        span = int'(timeout_reg) + int'(pulse_reg) + 4;
        n = $urandom_range(0, 1) ? span : $urandom_range(1, span);
        for (int k = 0; k < n && sent < budget; k++) begin
          health = ($urandom_range(0, 15) == 0) ? iss_pkg::HEALTH_OTHER : iss_pkg::HEALTH_OK;
          send_tick(tick_row(health, iss_pkg::COND_IDLE));
          sent++;
        end
        n = $urandom_range(1, 3);
        for (int k = 0; k < n && sent < budget; k++) begin
          cond = 2'($urandom_range(0, 2));
          if (cond == iss_pkg::COND_IDLE) cond = COND_UNDEFINED;
          health = $urandom_range(0, 1) ? iss_pkg::HEALTH_OTHER : iss_pkg::HEALTH_OK;
          send_tick(tick_row(health, cond));
          sent++;
        end
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n && sent < budget; k++) begin
          health = $urandom_range(0, 1) ? iss_pkg::HEALTH_OTHER : iss_pkg::HEALTH_OK;
          send_tick(tick_row(health, 2'($urandom_range(0, 3))));
          sent++;
        end
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    tick_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_ticks.size() == 0) begin
        $display("%0t: result with none expected, actual mode %0d remaining %0d",
                 $time, mode_o, remaining_o);
        mismatches++;
      end else begin
        want = due_ticks.pop_front();
        check_field("mode", want.mode, mode_o);
        check_field("relay_on", want.lamps.relay, relay_on_o);
        check_field("green_lamp", want.lamps.green, green_lamp_o);
        check_field("red_lamp", want.lamps.red, red_lamp_o);
        check_field("led_a", want.lamps.led_a, led_a_o);
        check_field("led_b", want.lamps.led_b, led_b_o);
        check_field("health_context", want.ctx, health_context_o);
        check_field("remaining", want.remaining, remaining_o);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("idle_stop_supervisor_core verification failed");
    $finish;
  end

  initial begin
    int budget[PHASES];
    logic [iss_pkg::TIMEOUT_W-1:0] t_val;
    logic [iss_pkg::WARN_W-1:0]    w_val;
    logic [iss_pkg::PULSE_W-1:0]   p_val;
    budget = '{120, 120, 150, 150, 900, 60, 150, 150};

    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_UNKNOWN,
                                iss_pkg::MODE_MON, iss_pkg::CTX_MON, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_IDLE, iss_pkg::CTX_MON, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_TIMER, iss_pkg::CTX_MON, 60000));
    script.push_back(tick_typed(iss_pkg::HEALTH_OTHER, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_TIMER, iss_pkg::CTX_MON, 59999));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, COND_UNDEFINED,
                                iss_pkg::MODE_MON, iss_pkg::CTX_MON, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_WORKING,
                                iss_pkg::MODE_MON, iss_pkg::CTX_MON, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, COND_UNDEFINED,
                                iss_pkg::MODE_MON, iss_pkg::CTX_MON, '0));
    script.push_back(write_row(iss_pkg::CFG_IDLE_TIMEOUT, 4));
    script.push_back(write_row(iss_pkg::CFG_WARN_WINDOW, 2));
    script.push_back(write_row(iss_pkg::CFG_RELAY_PULSE, 2));
    script.push_back(write_row(CFG_UNUSED, '1));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_IDLE, iss_pkg::CTX_MON, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_TIMER, iss_pkg::CTX_MON, 4));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_SDREQ, iss_pkg::CTX_MON, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_SDACT, iss_pkg::CTX_SDACT, '0));
    script.push_back(tick_row(iss_pkg::HEALTH_OTHER, iss_pkg::COND_WORKING));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_UNKNOWN,
                                iss_pkg::MODE_MON, iss_pkg::CTX_SDACT, '0));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_TIMER, iss_pkg::CTX_MON, 4));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_SDREQ, iss_pkg::CTX_MON, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OTHER, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_MON, iss_pkg::CTX_MON, '0));
    script.push_back(tick_row(iss_pkg::HEALTH_OK, iss_pkg::COND_WORKING));
    tail_start = script.size();
    script.push_back(tick_typed(iss_pkg::HEALTH_CAN_TMO, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_FAULT, iss_pkg::CTX_FAULT, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OK, iss_pkg::COND_WORKING,
                                iss_pkg::MODE_FAULT, iss_pkg::CTX_FAULT, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_CAN_ERR, COND_UNDEFINED,
                                iss_pkg::MODE_FAULT, iss_pkg::CTX_FAULT, '0));
    script.push_back(tick_typed(iss_pkg::HEALTH_OTHER, iss_pkg::COND_IDLE,
                                iss_pkg::MODE_FAULT, iss_pkg::CTX_FAULT, '0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_odds = 4;
    stall_odds = 4;
    walk_script(0, tail_start - 1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin t_val = 1; w_val = 0; p_val = 1; end
        1: begin t_val = 0; w_val = 0; p_val = 0; end
        2: begin t_val = 10; w_val = 3; p_val = 5; end
        3: begin t_val = 30; w_val = '1; p_val = 20; end
        4: begin t_val = 3; w_val = 1; p_val = '1; end
        5: begin t_val = '1; w_val = '1; p_val = '1; end
        default: begin
          t_val = iss_pkg::TIMEOUT_W'($urandom_range(1, 48));
          w_val = iss_pkg::WARN_W'($urandom_range(0, 50));
          p_val = iss_pkg::PULSE_W'($urandom_range(1, 40));
        end
      endcase
      drain();
      write_reg(iss_pkg::CFG_IDLE_TIMEOUT, t_val);
      write_reg(iss_pkg::CFG_WARN_WINDOW, w_val);
      write_reg(iss_pkg::CFG_RELAY_PULSE,
                {(iss_pkg::CFG_DW - iss_pkg::PULSE_W)'($urandom), p_val});
      send_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      run_phase(budget[p]);
    end

    send_odds = 0;
    stall_odds = 0;
    walk_script(tail_start, script.size() - 1);
    repeat (40) send_tick(tick_row(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("idle_stop_supervisor_core verification clean");
    end else begin
      $display("idle_stop_supervisor_core verification failed");
    end
    $finish;
  end

endmodule
